>>> design/dsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types and constants of the damped spring force pipeline.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned DW        = 33;   // coordinate difference width
  localparam int unsigned SQ_W      = 66;   // squared length width
  localparam int unsigned ROOT_W    = 33;   // distance width
  localparam int unsigned QW        = 17;   // unit vector magnitude width
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST_LENGTH  = 2'd0,
    REG_STIFFNESS    = 2'd1,
    REG_DAMPING      = 2'd2,
    REG_MIN_DISTANCE = 2'd3
  } cfg_reg_t;

  localparam logic [30:0] REST_LENGTH_RST  = 31'd65536;
  localparam logic [30:0] STIFFNESS_RST    = 31'd65536;
  localparam logic [30:0] DAMPING_RST      = 31'd0;
  localparam logic [15:0] MIN_DISTANCE_RST = 16'd66;

  // travels beside the square root
  typedef struct packed {
    logic [AXES-1:0][DW-1:0] dmag;
    logic [AXES-1:0]         dneg;
    logic [AXES-1:0][DW-1:0] vel;
  } sqrt_side_t;

  // travels beside the dividers
  typedef struct packed {
    logic [AXES-1:0][DW-1:0] vel;
    logic [AXES-1:0]         dneg;
    logic [ROOT_W-1:0]       dlen;
    logic                    applied;
  } div_side_t;

endpackage

>>> design/dsf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_sqrt
// Floor square root of a 66 bit value, one result bit per stage, 33 stages.
// ----------------------------------------------------------------------------
module dsf_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [dsf_pkg::SQ_W-1:0]  in_val,
  input  dsf_pkg::sqrt_side_t       in_side,
  output logic                      out_valid,
  output logic [dsf_pkg::ROOT_W-1:0] out_root,
  output dsf_pkg::sqrt_side_t       out_side
);
  import dsf_pkg::*;

  localparam int unsigned NST   = ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic                  vld_r  [NST+1];
  logic [SQ_W-1:0]       val_r  [NST+1];
  logic [REM_W-1:0]      rem_r  [NST+1];
  logic [ROOT_W-1:0]     root_r [NST+1];
  sqrt_side_t            side_r [NST+1];

  assign vld_r[0]  = in_valid;
  assign val_r[0]  = in_val;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    always_comb begin
      rem_sh = {rem_r[s], val_r[s][2*(NST-1-s) +: 2]};
      trial  = {1'b0, root_r[s], 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      val_r[s+1]  <= val_r[s];
      side_r[s+1] <= side_r[s];
      rem_r[s+1]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r[s+1] <= {root_r[s][ROOT_W-2:0], take};
    end
  end

  assign out_valid = vld_r[NST];
  assign out_root  = root_r[NST];
  assign out_side  = side_r[NST];

endmodule

>>> design/dsf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_div
// Three restoring dividers, |d| * 2^16 / dist, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dsf_div (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  dsf_pkg::div_side_t                        in_side,
  input  logic [dsf_pkg::AXES-1:0][dsf_pkg::DW-1:0] in_dmag,
  output logic                                      out_valid,
  output logic [dsf_pkg::AXES-1:0][dsf_pkg::QW-1:0] out_q,
  output dsf_pkg::div_side_t                        out_side
);
  import dsf_pkg::*;

  localparam int unsigned NST   = QW;
  localparam int unsigned REM_W = ROOT_W;

  logic                          vld_r  [NST+1];
  logic [AXES-1:0][REM_W-1:0]    rem_r  [NST+1];
  logic [AXES-1:0][QW-1:0]       q_r    [NST+1];
  logic [AXES-1:0]               lsb_r  [NST+1];
  div_side_t                     side_r [NST+1];

  assign vld_r[0]  = in_valid;
  assign side_r[0] = in_side;
  for (genvar k = 0; k < AXES; k++) begin : g_init
    // numerator >> 17 seeds the remainder; bit 0 of |d| is shifted in at the first stage
    assign rem_r[0][k] = {1'b0, in_dmag[k][DW-1:1]};
    assign lsb_r[0][k] = in_dmag[k][0];
    assign q_r[0][k]   = '0;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [AXES-1:0][REM_W:0] rem_sh;
    logic [AXES-1:0]          take;

    always_comb begin
      for (int k = 0; k < AXES; k++) begin
        rem_sh[k] = {rem_r[s][k], (s == 0) ? lsb_r[s][k] : 1'b0};
        take[k]   = (rem_sh[k] >= {1'b0, side_r[s].dlen});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      side_r[s+1] <= side_r[s];
      lsb_r[s+1]  <= lsb_r[s];
      for (int k = 0; k < AXES; k++) begin
        rem_r[s+1][k] <= take[k] ? REM_W'(rem_sh[k] - {1'b0, side_r[s].dlen})
                                 : REM_W'(rem_sh[k]);
        q_r[s+1][k]   <= {q_r[s][k][QW-2:0], take[k]};
      end
    end
  end

  assign out_valid = vld_r[NST];
  assign out_q     = q_r[NST];
  assign out_side  = side_r[NST];

endmodule

>>> design/damped_spring_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_force_top
// Damped Hooke spring force between two particles, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve in_* position and velocity fields and pulse start. A
//   word is taken on every clock edge with start high; busy is always low,
//   so a new pair may follow in every cycle.
//   The force on the second particle appears on out_force_x/y/z with
//   out_applied, qualified by out_valid for one cycle. Throughput is one
//   word per cycle. The pipeline is the 33 stage square root (one root bit
//   per stage) and the 17 stage dividers (one quotient bit per stage), plus
//   13 stages of difference, square, multiply and saturation logic. The
//   receiver cannot stall; every result is presented exactly once.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is to be written by the user
//   only while no word is in flight; the block does not enforce this. Reset
//   empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module damped_spring_force_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               in_a_pos_x,
  input  logic signed [31:0]               in_a_pos_y,
  input  logic signed [31:0]               in_a_pos_z,
  input  logic signed [31:0]               in_b_pos_x,
  input  logic signed [31:0]               in_b_pos_y,
  input  logic signed [31:0]               in_b_pos_z,
  input  logic signed [31:0]               in_a_vel_x,
  input  logic signed [31:0]               in_a_vel_y,
  input  logic signed [31:0]               in_a_vel_z,
  input  logic signed [31:0]               in_b_vel_x,
  input  logic signed [31:0]               in_b_vel_y,
  input  logic signed [31:0]               in_b_vel_z,
  input  logic                             cfg_we,
  input  logic [dsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsf_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                             out_valid,
  output logic signed [31:0]               out_force_x,
  output logic signed [31:0]               out_force_y,
  output logic signed [31:0]               out_force_z,
  output logic                             out_applied
);
  import dsf_pkg::*;

  // ---------------- configuration ----------------
  logic [30:0] rest_r, stiff_r, damp_r;
  logic [15:0] mind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= REST_LENGTH_RST;
      stiff_r <= STIFFNESS_RST;
      damp_r  <= DAMPING_RST;
      mind_r  <= MIN_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_REST_LENGTH:  rest_r  <= cfg_wdata;
        REG_STIFFNESS:    stiff_r <= cfg_wdata;
        REG_DAMPING:      damp_r  <= cfg_wdata;
        REG_MIN_DISTANCE: mind_r  <= cfg_wdata[15:0];
        default:          ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: differences ----------------
  logic [AXES-1:0][31:0] apos, bpos, avel, bvel;
  assign apos = {in_a_pos_z, in_a_pos_y, in_a_pos_x};
  assign bpos = {in_b_pos_z, in_b_pos_y, in_b_pos_x};
  assign avel = {in_a_vel_z, in_a_vel_y, in_a_vel_x};
  assign bvel = {in_b_vel_z, in_b_vel_y, in_b_vel_x};

  logic [AXES-1:0][DW-1:0] d_c, v_c;
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      d_c[k] = {apos[k][31], apos[k]} - {bpos[k][31], bpos[k]};
      v_c[k] = {avel[k][31], avel[k]} - {bvel[k][31], bvel[k]};
    end
  end

  logic       v1_r;
  sqrt_side_t s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    for (int k = 0; k < AXES; k++) begin
      s1_r.dneg[k] <= d_c[k][DW-1];
      s1_r.dmag[k] <= d_c[k][DW-1] ? DW'(-d_c[k]) : d_c[k];
      s1_r.vel[k]  <= v_c[k];
    end
  end

  // ---------------- stage 2: squares ----------------
  logic                      v2_r;
  sqrt_side_t                s2_r;
  logic [AXES-1:0][SQ_W-1:0] sq2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s2_r <= s1_r;
    for (int k = 0; k < AXES; k++) begin
      sq2_r[k] <= s1_r.dmag[k] * s1_r.dmag[k];
    end
  end

  // ---------------- stage 3: squared length ----------------
  logic            v3_r;
  sqrt_side_t      s3_r;
  logic [SQ_W-1:0] sum3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s3_r   <= s2_r;
    sum3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
  end

  // ---------------- square root ----------------
  logic              vr_w;
  logic [ROOT_W-1:0] root_w;
  sqrt_side_t        sr_w;

  dsf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_val    (sum3_r),
    .in_side   (s3_r),
    .out_valid (vr_w),
    .out_root  (root_w),
    .out_side  (sr_w)
  );

  // ---------------- threshold ----------------
  logic                    v4_r;
  div_side_t               s4_r;
  logic [AXES-1:0][DW-1:0] dmag4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vr_w;
    end
    s4_r.vel     <= sr_w.vel;
    s4_r.dneg    <= sr_w.dneg;
    s4_r.dlen    <= root_w;
    s4_r.applied <= (root_w > {{(ROOT_W-16){1'b0}}, mind_r});
    dmag4_r      <= sr_w.dmag;
  end

  // ---------------- unit direction ----------------
  logic                    vd_w;
  logic [AXES-1:0][QW-1:0] q_w;
  div_side_t               sd_w;

  dsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_side   (s4_r),
    .in_dmag   (dmag4_r),
    .out_valid (vd_w),
    .out_q     (q_w),
    .out_side  (sd_w)
  );

  // ---------------- P1: signed unit vector, stretch ----------------
  logic                    p1_v_r, p1_app_r, p1_sneg_r;
  logic [AXES-1:0][QW:0]   p1_u_r;
  logic [AXES-1:0][QW-1:0] p1_umag_r;
  logic [AXES-1:0]         p1_uneg_r;
  logic [AXES-1:0][DW-1:0] p1_vel_r;
  logic [ROOT_W-1:0]       p1_smag_r;
  logic signed [ROOT_W:0]  stretch_c;

  assign stretch_c = $signed({1'b0, sd_w.dlen}) - $signed({3'b000, rest_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= vd_w;
    end
    p1_app_r  <= sd_w.applied;
    p1_vel_r  <= sd_w.vel;
    p1_sneg_r <= stretch_c[ROOT_W];
    p1_smag_r <= stretch_c[ROOT_W] ? ROOT_W'(-stretch_c) : ROOT_W'(stretch_c);
    p1_umag_r <= q_w;
    p1_uneg_r <= sd_w.dneg;
    for (int k = 0; k < AXES; k++) begin
      p1_u_r[k] <= sd_w.dneg[k] ? (QW+1)'(-{1'b0, q_w[k]}) : {1'b0, q_w[k]};
    end
  end

  // ---------------- P2: v*u, stiffness product ----------------
  localparam int unsigned PV_W = DW + QW + 1;
  logic                          p2_v_r, p2_app_r, p2_sneg_r;
  logic [AXES-1:0][PV_W-1:0]     p2_pv_r;
  logic [ROOT_W+30:0]            p2_sprod_r;
  logic [AXES-1:0][QW-1:0]       p2_umag_r;
  logic [AXES-1:0]               p2_uneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
    p2_app_r   <= p1_app_r;
    p2_sneg_r  <= p1_sneg_r;
    p2_umag_r  <= p1_umag_r;
    p2_uneg_r  <= p1_uneg_r;
    p2_sprod_r <= p1_smag_r * stiff_r;
    for (int k = 0; k < AXES; k++) begin
      p2_pv_r[k] <= PV_W'($signed(p1_vel_r[k]) * $signed(p1_u_r[k]));
    end
  end

  // ---------------- P3: dot product, stiffness term ----------------
  localparam int unsigned DS_W = PV_W + 2;
  localparam int unsigned DM_W = DS_W - 16;
  localparam int unsigned ST_W = ROOT_W + 31 - 16;
  logic signed [DS_W-1:0] dsum_c;
  logic [DS_W-1:0]        dabs_c;
  assign dsum_c = $signed(p2_pv_r[0]) + $signed(p2_pv_r[1]) + $signed(p2_pv_r[2]);
  assign dabs_c = dsum_c[DS_W-1] ? DS_W'(-dsum_c) : DS_W'(dsum_c);

  logic                    p3_v_r, p3_app_r, p3_sneg_r, p3_dneg_r;
  logic [DM_W-1:0]         p3_dmag_r;
  logic [ST_W-1:0]         p3_sterm_r;
  logic [AXES-1:0][QW-1:0] p3_umag_r;
  logic [AXES-1:0]         p3_uneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= p2_v_r;
    end
    p3_app_r   <= p2_app_r;
    p3_sneg_r  <= p2_sneg_r;
    p3_umag_r  <= p2_umag_r;
    p3_uneg_r  <= p2_uneg_r;
    p3_dneg_r  <= dsum_c[DS_W-1];
    p3_dmag_r  <= dabs_c[DS_W-1:16];
    p3_sterm_r <= p2_sprod_r[ROOT_W+30:16];
  end

  // ---------------- P4: damping partial products ----------------
  localparam int unsigned DLO_W = 18;
  localparam int unsigned DHI_W = DM_W - DLO_W;
  logic                    p4_v_r, p4_app_r, p4_sneg_r, p4_dneg_r;
  logic [DLO_W+30:0]       p4_dlo_r;
  logic [DHI_W+30:0]       p4_dhi_r;
  logic [ST_W-1:0]         p4_sterm_r;
  logic [AXES-1:0][QW-1:0] p4_umag_r;
  logic [AXES-1:0]         p4_uneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else begin
      p4_v_r <= p3_v_r;
    end
    p4_app_r   <= p3_app_r;
    p4_sneg_r  <= p3_sneg_r;
    p4_dneg_r  <= p3_dneg_r;
    p4_sterm_r <= p3_sterm_r;
    p4_umag_r  <= p3_umag_r;
    p4_uneg_r  <= p3_uneg_r;
    p4_dlo_r   <= p3_dmag_r[DLO_W-1:0] * damp_r;
    p4_dhi_r   <= p3_dmag_r[DM_W-1:DLO_W] * damp_r;
  end

  // ---------------- P5: damping term ----------------
  localparam int unsigned DP_W = DM_W + 31;
  localparam int unsigned DT_W = DP_W - 16;
  logic [DP_W-1:0] dprod_c;
  assign dprod_c = {p4_dhi_r, {DLO_W{1'b0}}} + DP_W'(p4_dlo_r);

  logic                    p5_v_r, p5_app_r, p5_sneg_r, p5_dneg_r;
  logic [DT_W-1:0]         p5_dterm_r;
  logic [ST_W-1:0]         p5_sterm_r;
  logic [AXES-1:0][QW-1:0] p5_umag_r;
  logic [AXES-1:0]         p5_uneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else begin
      p5_v_r <= p4_v_r;
    end
    p5_app_r   <= p4_app_r;
    p5_sneg_r  <= p4_sneg_r;
    p5_dneg_r  <= p4_dneg_r;
    p5_sterm_r <= p4_sterm_r;
    p5_umag_r  <= p4_umag_r;
    p5_uneg_r  <= p4_uneg_r;
    p5_dterm_r <= dprod_c[DP_W-1:16];
  end

  // ---------------- P6: force magnitude ----------------
  localparam int unsigned MG_W = DT_W + 2;
  logic signed [MG_W-1:0] s_c, d_sgn_c;
  assign s_c     = p5_sneg_r ? -$signed(MG_W'(p5_sterm_r)) : $signed(MG_W'(p5_sterm_r));
  assign d_sgn_c = p5_dneg_r ? -$signed(MG_W'(p5_dterm_r)) : $signed(MG_W'(p5_dterm_r));

  logic                    p6_v_r, p6_app_r;
  logic signed [MG_W-1:0]  p6_mag_r;
  logic [AXES-1:0][QW-1:0] p6_umag_r;
  logic [AXES-1:0]         p6_uneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else begin
      p6_v_r <= p5_v_r;
    end
    p6_app_r  <= p5_app_r;
    p6_umag_r <= p5_umag_r;
    p6_uneg_r <= p5_uneg_r;
    p6_mag_r  <= s_c - d_sgn_c;
  end

  // ---------------- P7: magnitude times unit, partial products ----------------
  localparam int unsigned ML_W = 26;
  localparam int unsigned MH_W = MG_W - ML_W;
  logic [MG_W-1:0] mabs_c;
  assign mabs_c = p6_mag_r[MG_W-1] ? MG_W'(-p6_mag_r) : MG_W'(p6_mag_r);

  logic                          p7_v_r, p7_app_r;
  logic [AXES-1:0][ML_W+QW-1:0]  p7_lo_r;
  logic [AXES-1:0][MH_W+QW-1:0]  p7_hi_r;
  logic [AXES-1:0]               p7_fneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_v_r <= 1'b0;
    end else begin
      p7_v_r <= p6_v_r;
    end
    p7_app_r <= p6_app_r;
    for (int k = 0; k < AXES; k++) begin
      p7_lo_r[k]   <= mabs_c[ML_W-1:0] * p6_umag_r[k];
      p7_hi_r[k]   <= mabs_c[MG_W-1:ML_W] * p6_umag_r[k];
      p7_fneg_r[k] <= p6_mag_r[MG_W-1] ^ p6_uneg_r[k];
    end
  end

  // ---------------- P8: combine and scale ----------------
  localparam int unsigned FP_W = MG_W + QW;
  localparam int unsigned FM_W = FP_W - 16;
  logic [AXES-1:0][FP_W-1:0] fprod_c;
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      fprod_c[k] = {p7_hi_r[k], {ML_W{1'b0}}} + FP_W'(p7_lo_r[k]);
    end
  end

  logic                      p8_v_r, p8_app_r;
  logic [AXES-1:0][FM_W-1:0] p8_fm_r;
  logic [AXES-1:0]           p8_fneg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_v_r <= 1'b0;
    end else begin
      p8_v_r <= p7_v_r;
    end
    p8_app_r  <= p7_app_r;
    p8_fneg_r <= p7_fneg_r;
    for (int k = 0; k < AXES; k++) begin
      p8_fm_r[k] <= fprod_c[k][FP_W-1:16];
    end
  end

  // ---------------- P9: saturate, output word ----------------
  localparam logic [FM_W-1:0] POS_MAX = FM_W'(32'h7FFF_FFFF);
  localparam logic [FM_W-1:0] NEG_MAX = FM_W'(32'h8000_0000);
  logic [AXES-1:0][31:0] sat_c;
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      if (!p8_app_r) begin
        sat_c[k] = '0;
      end else if (p8_fneg_r[k]) begin
        sat_c[k] = (p8_fm_r[k] >= NEG_MAX) ? 32'h8000_0000 : 32'(-p8_fm_r[k]);
      end else begin
        sat_c[k] = (p8_fm_r[k] > POS_MAX) ? 32'h7FFF_FFFF : p8_fm_r[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p8_v_r;
    end
    out_applied <= p8_app_r;
    out_force_x <= sat_c[0];
    out_force_y <= sat_c[1];
    out_force_z <= sat_c[2];
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for damped_spring_force_top. A driver sends particle
// pairs from a queue and a monitor compares every force word with a local
// fixed-point model of the spring, under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import dsf_pkg::*;

  localparam int LATENCY = 63;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] fld [12];   // a_pos xyz, b_pos xyz, a_vel xyz, b_vel xyz
  } pair_t;

  typedef struct {
    logic signed [31:0] frc [3];
    logic               applied;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_a_pos_x = '0, in_a_pos_y = '0, in_a_pos_z = '0;
  logic signed [31:0] in_b_pos_x = '0, in_b_pos_y = '0, in_b_pos_z = '0;
  logic signed [31:0] in_a_vel_x = '0, in_a_vel_y = '0, in_a_vel_z = '0;
  logic signed [31:0] in_b_vel_x = '0, in_b_vel_y = '0, in_b_vel_z = '0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               out_valid;
  logic signed [31:0] out_force_x, out_force_y, out_force_z;
  logic               out_applied;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  pair_t  cur_pair;
  int     idle_pct = 0;
  int     fails = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_applied = 0;
  int     cycles = 0;

  // spring registers as the block should hold them
  logic [30:0] rest_len_q = REST_LENGTH_RST;
  logic [30:0] stiff_q    = STIFFNESS_RST;
  logic [30:0] damp_q     = DAMPING_RST;
  logic [15:0] min_dist_q = MIN_DISTANCE_RST;

  damped_spring_force_top u_dut (
    .clk, .rst_n, .start, .busy,
    .in_a_pos_x, .in_a_pos_y, .in_a_pos_z,
    .in_b_pos_x, .in_b_pos_y, .in_b_pos_z,
    .in_a_vel_x, .in_a_vel_y, .in_a_vel_z,
    .in_b_vel_x, .in_b_vel_y, .in_b_vel_z,
    .cfg_we, .cfg_index, .cfg_wdata,
    .out_valid, .out_force_x, .out_force_y, .out_force_z, .out_applied
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_forces.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // (|a| * |b|) >> 16 with the sign of the product, capped at 2^60
  function automatic longint qmul(longint a, longint b);
    logic [127:0] ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb) >> 16;
    if (p > (128'd1 << 60)) p = 128'd1 << 60;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (x < -64'sh80000000) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic force_t spring_force(pair_t p);
    force_t r;
    longint d[3], v[3], u[3], md, dot, mag;
    logic [67:0] len_sq;
    longint unsigned rem, root, trial, dist_v;
    len_sq = '0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(signed'(p.fld[i])) - longint'(signed'(p.fld[3+i]));
      v[i] = longint'(signed'(p.fld[6+i])) - longint'(signed'(p.fld[9+i]));
      md = (d[i] < 0) ? -d[i] : d[i];
      len_sq += 68'(md) * 68'(md);
    end
    // bitwise floor square root, two bits per step
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | len_sq[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    dist_v = root;
    if (dist_v <= min_dist_q) begin
      foreach (r.frc[i]) r.frc[i] = '0;
      r.applied = 1'b0;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      md = (d[i] < 0) ? -d[i] : d[i];
      u[i] = longint'((unsigned'(md) << 16) / dist_v);
      if (d[i] < 0) u[i] = -u[i];
      dot += v[i] * u[i];
    end
    dot = (dot < 0) ? -((-dot) >>> 16) : (dot >>> 16);
    mag = qmul(longint'(dist_v) - longint'(rest_len_q), longint'(stiff_q))
        - qmul(dot, longint'(damp_q));
    for (int i = 0; i < 3; i++) r.frc[i] = clip32(qmul(mag, u[i]));
    r.applied = 1'b1;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_forces.push_back(spring_force(cur_pair));
        n_sent++;
      end
      if (!start || !busy) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_pair = pending_pairs.pop_front();
          start <= 1'b1;
          in_a_pos_x <= cur_pair.fld[0];
          in_a_pos_y <= cur_pair.fld[1];
          in_a_pos_z <= cur_pair.fld[2];
          in_b_pos_x <= cur_pair.fld[3];
          in_b_pos_y <= cur_pair.fld[4];
          in_b_pos_z <= cur_pair.fld[5];
          in_a_vel_x <= cur_pair.fld[6];
          in_a_vel_y <= cur_pair.fld[7];
          in_a_vel_z <= cur_pair.fld[8];
          in_b_vel_x <= cur_pair.fld[9];
          in_b_vel_y <= cur_pair.fld[10];
          in_b_vel_z <= cur_pair.fld[11];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    force_t exp_f;
    logic signed [31:0] got [3];
    if (rst_n && out_valid) begin
      got[0] = out_force_x;
      got[1] = out_force_y;
      got[2] = out_force_z;
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected word, force %0d %0d %0d applied %0b", $time,
                 got[0], got[1], got[2], out_applied);
        fails++;
      end else begin
        exp_f = expected_forces.pop_front();
        n_checked++;
        if (exp_f.applied) n_applied++;
        for (int i = 0; i < 3; i++)
          if (got[i] !== exp_f.frc[i]) begin
            $display("%0t: force[%0d] expected %0d actual %0d", $time, i,
                     exp_f.frc[i], got[i]);
            fails++;
          end
        if (out_applied !== exp_f.applied) begin
          $display("%0t: applied expected %0b actual %0b", $time,
                   exp_f.applied, out_applied);
          fails++;
        end
      end
    end
  end

  task automatic wait_drained();
    wait (pending_pairs.size() == 0 && expected_forces.size() == 0 && !start);
    repeat (5) @(posedge clk);
  endtask

  // cfg_we stays high across the four writes and drops after the last
  task automatic set_spring(logic [30:0] rl, logic [30:0] st, logic [30:0] dp,
                            logic [30:0] md_raw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_REST_LENGTH;
    cfg_wdata <= rl;
    @(posedge clk);
    cfg_index <= REG_STIFFNESS;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_index <= REG_DAMPING;
    cfg_wdata <= dp;
    @(posedge clk);
    cfg_index <= REG_MIN_DISTANCE;
    cfg_wdata <= md_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    rest_len_q = rl;
    stiff_q = st;
    damp_q = dp;
    min_dist_q = md_raw[15:0];
  endtask

  function automatic logic [31:0] pick_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
      default: begin
        case ($urandom_range(3))
          0: return 32'h80000000;
          1: return 32'h7FFFFFFF;
          2: return 32'h0;
          default: return 32'hFFFFFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int shape, kind;
    shape = $urandom_range(99);
    kind = (shape < 60) ? 1 : (shape < 80) ? 0 : 2;
    foreach (p.fld[i]) p.fld[i] = pick_coord(kind);
    if (shape >= 60 && shape < 75) begin
      // nearly coincident particles, around the cutoff distance
      for (int i = 0; i < 3; i++)
        p.fld[3+i] = p.fld[i] + 32'($signed($urandom_range(0, 200)) - 100);
    end
    return p;
  endfunction

  function automatic pair_t make_pair(logic [31:0] ax, logic [31:0] bx,
                                      logic [31:0] av, logic [31:0] bv);
    pair_t p;
    foreach (p.fld[i]) p.fld[i] = '0;
    p.fld[0] = ax;
    p.fld[3] = bx;
    p.fld[6] = av;
    p.fld[9] = bv;
    return p;
  endfunction

  task automatic queue_random(int n, int pct);
    idle_pct = pct;
    repeat (n) pending_pairs.push_back(random_pair());
  endtask

  initial begin
    pair_t p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed, default registers
    idle_pct = 23;
    pending_pairs.push_back(make_pair(0, 0, 0, 0));                  // coincident
    pending_pairs.push_back(make_pair(66, 0, 0, 0));                 // at cutoff
    pending_pairs.push_back(make_pair(67, 0, 0, 0));                 // just above
    pending_pairs.push_back(make_pair(0, 67, 32'h7FFFFFFF, 32'h80000000));
    pending_pairs.push_back(make_pair(32'h00010000, 0, 0, 0));       // at rest length
    pending_pairs.push_back(make_pair(32'h7FFFFFFF, 32'h80000000, 0, 0));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h7FFFFFFF, 0, 0));
    pending_pairs.push_back(make_pair(32'h00020000, 32'hFFFF0000, 5, 9));
    foreach (p.fld[i]) p.fld[i] = (i < 3) ? 32'h7FFFFFFF : (i < 6) ? 32'h80000000 :
                                  (i < 9) ? 32'h80000000 : 32'h7FFFFFFF;
    pending_pairs.push_back(p);
    foreach (p.fld[i]) p.fld[i] = (i < 6) ? ((i % 3 == 1) ? 32'h00030000 : 0) : 32'hFFFFFFFF;
    pending_pairs.push_back(p);
    wait_drained();

    // directed with strong damping and wide cutoff
    set_spring(31'h00008000, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    pending_pairs.push_back(make_pair(32'h0000FFFF, 0, 32'h7FFFFFFF, 32'h80000000));
    pending_pairs.push_back(make_pair(32'h00010000, 0, 32'h7FFFFFFF, 32'h80000000));
    pending_pairs.push_back(make_pair(32'h00040000, 0, 32'h80000000, 32'h7FFFFFFF));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h7FFFFFFF, 32'h12345678, 0));
    pending_pairs.push_back(make_pair(0, 32'h00100000, 0, 32'h00010000));
    wait_drained();

    // random: sender idles rarely at first, then often, then never
    queue_random(200, 23);
    wait_drained();
    set_spring(31'h7FFFFFFF, 31'h00001000, 31'h00000100, 31'h7FFF0000);
    queue_random(200, 72);
    wait_drained();
    set_spring(31'h0, 31'h0, 31'h00020000, 31'h0);
    queue_random(150, 72);
    wait_drained();
    set_spring(31'h00030000, 31'h00050000, 31'h00008000, 31'h00000100);
    queue_random(200, 0);
    wait_drained();
    set_spring(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
    queue_random(200, 0);
    wait_drained();
    set_spring(REST_LENGTH_RST, STIFFNESS_RST, 31'h00010000, 31'h5A5A0042);
    queue_random(185, 0);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d pairs over 7 register settings; %0d forces checked, %0d above cutoff.",
             n_sent, n_checked, n_applied);
    if (fails == 0 && expected_forces.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
